>>> rtl/imk_pkg.sv
// imk_pkg: shared constants, types and length lookups for the iambic keyer
// no dependencies; imported by every rtl file of the keyer
`timescale 1ns / 1ps

package imk_pkg;

   localparam int TIMER_BITS = 12;
   localparam int DAH_DITS   = 3;
   localparam int DIT_BITS   = 11;
   localparam int WPM_BITS   = 7;
   localparam int PROD_BITS  = (DIT_BITS + 3 > TIMER_BITS) ? DIT_BITS + 3 : TIMER_BITS;

   localparam logic [TIMER_BITS-1:0] TIMER_MAX    = {TIMER_BITS{1'b1}};
   localparam logic [TIMER_BITS-1:0] INTERVAL_CAP = TIMER_MAX - 1'b1;

   // keyer mode codes, mode three runs as iambic a
   localparam logic [1:0] MODE_STRAIGHT = 2'd0;
   localparam logic [1:0] MODE_IAMBIC_A = 2'd1;
   localparam logic [1:0] MODE_IAMBIC_B = 2'd2;

   // key line event codes
   localparam logic [1:0] KEY_NONE    = 2'd0;
   localparam logic [1:0] KEY_PRESS   = 2'd1;
   localparam logic [1:0] KEY_RELEASE = 2'd2;

   // stuck key event codes
   localparam logic [1:0] ERR_NONE  = 2'd0;
   localparam logic [1:0] ERR_STUCK = 2'd1;
   localparam logic [1:0] ERR_CLEAR = 2'd2;

   // 1200 / wpm in ms, zero speed read as one wpm
   localparam logic [DIT_BITS-1:0] DIT_TABLE [2**WPM_BITS] = '{
      1200, 1200, 600, 400, 300, 240, 200, 171, 150, 133, 120, 109, 100, 92, 85, 80,
      75, 70, 66, 63, 60, 57, 54, 52, 50, 48, 46, 44, 42, 41, 40, 38,
      37, 36, 35, 34, 33, 32, 31, 30, 30, 29, 28, 27, 27, 26, 26, 25,
      25, 24, 24, 23, 23, 22, 22, 21, 21, 21, 20, 20, 20, 19, 19, 19,
      18, 18, 18, 17, 17, 17, 17, 16, 16, 16, 16, 16, 15, 15, 15, 15,
      15, 14, 14, 14, 14, 14, 13, 13, 13, 13, 13, 13, 13, 12, 12, 12,
      12, 12, 12, 12, 12, 11, 11, 11, 11, 11, 11, 11, 11, 11, 10, 10,
      10, 10, 10, 10, 10, 10, 10, 10, 10, 9, 9, 9, 9, 9, 9, 9
   };

   typedef struct packed {
      logic [1:0]            mode;
      logic                  swap;
      logic [TIMER_BITS-1:0] dit_len;
      logic [TIMER_BITS-1:0] dah_len;
   } imk_cfg_type;

   function automatic logic [TIMER_BITS-1:0] dit_length(input logic [WPM_BITS-1:0] wpm);
      logic [PROD_BITS-1:0] dit;
      dit = PROD_BITS'(DIT_TABLE[wpm]);
      if (dit > PROD_BITS'(INTERVAL_CAP)) begin
         dit = PROD_BITS'(INTERVAL_CAP);
      end
      return dit[TIMER_BITS-1:0];
   endfunction

   function automatic logic [TIMER_BITS-1:0] dah_length(input logic [WPM_BITS-1:0] wpm);
      logic [PROD_BITS-1:0] prod;
      prod = PROD_BITS'(DIT_TABLE[wpm]) * PROD_BITS'(DAH_DITS);
      if (prod > PROD_BITS'(INTERVAL_CAP)) begin
         prod = PROD_BITS'(INTERVAL_CAP);
      end
      return prod[TIMER_BITS-1:0];
   endfunction

endpackage

>>> rtl/iambic_morse_keyer.sv
// iambic_morse_keyer: top level, register file plus keyer core
// depends on imk_pkg, imk_csr and imk_core
//
//  channel  direction  handshake             payload
//  req      in         req_valid/req_stall   tip_pressed, ring_pressed, ms_elapsed
//  rsp      out        rsp_valid/rsp_stall   key_event, error_event, key_down
//  csr      in/out     psel/penable/pready   mode 0x0, wpm 0x4, swap 0x8
//
// one item per cycle while req_stall is low; each item's result is registered
// the keyer state updates in one step per item, feeding a result register
// a two-deep result buffer lets one more item in while rsp is stalled
// synchronous active-high reset: idle, 12 wpm, straight mode, no swap
`timescale 1ns / 1ps

module iambic_morse_keyer (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_tip_pressed,
   input  logic        req_ring_pressed,
   input  logic        req_ms_elapsed,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_key_event,
   output logic [1:0]  rsp_error_event,
   output logic        rsp_key_down,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [3:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);
   import imk_pkg::*;

   imk_cfg_type cfg;

   imk_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   imk_core u_core (
      .clock            (clock),
      .reset            (reset),
      .cfg              (cfg),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_tip_pressed  (req_tip_pressed),
      .req_ring_pressed (req_ring_pressed),
      .req_ms_elapsed   (req_ms_elapsed),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_key_event    (rsp_key_event),
      .rsp_error_event  (rsp_error_event),
      .rsp_key_down     (rsp_key_down)
   );

endmodule

>>> rtl/imk_csr.sv
// imk_csr: apb-style register file for mode, speed and paddle swap
// depends on imk_pkg; element lengths are looked up when speed is written
`timescale 1ns / 1ps

module imk_csr (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_psel,
   input  logic                 csr_penable,
   input  logic                 csr_pwrite,
   input  logic [3:0]           csr_paddr,
   input  logic [31:0]          csr_pwdata,
   output logic [31:0]          csr_prdata,
   output logic                 csr_pready,
   output imk_pkg::imk_cfg_type cfg
);
   import imk_pkg::*;

   localparam logic [1:0] REG_MODE = 2'd0;
   localparam logic [1:0] REG_WPM  = 2'd1;
   localparam logic [1:0] REG_SWAP = 2'd2;

   localparam logic [WPM_BITS-1:0] WPM_RESET = 7'd12;

   logic [1:0]            mode_ff;
   logic [WPM_BITS-1:0]   wpm_ff;
   logic                  swap_ff;
   logic [TIMER_BITS-1:0] dit_ff;
   logic [TIMER_BITS-1:0] dah_ff;
   logic                  wr_en;
   logic [1:0]            reg_index;

   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel & csr_penable & csr_pwrite;
   assign reg_index  = csr_paddr[3:2];

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_STRAIGHT;
         wpm_ff  <= WPM_RESET;
         swap_ff <= 1'b0;
         dit_ff  <= dit_length(WPM_RESET);
         dah_ff  <= dah_length(WPM_RESET);
      end else if (wr_en) begin
         unique case (reg_index)
            REG_MODE: begin
               mode_ff <= csr_pwdata[1:0];
            end
            REG_WPM: begin
               wpm_ff <= csr_pwdata[WPM_BITS-1:0];
               dit_ff <= dit_length(csr_pwdata[WPM_BITS-1:0]);
               dah_ff <= dah_length(csr_pwdata[WPM_BITS-1:0]);
            end
            REG_SWAP: begin
               swap_ff <= csr_pwdata[0];
            end
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      unique case (reg_index)
         REG_MODE: csr_prdata = {30'd0, mode_ff};
         REG_WPM:  csr_prdata = {{(32 - WPM_BITS){1'b0}}, wpm_ff};
         REG_SWAP: csr_prdata = {31'd0, swap_ff};
         default:  csr_prdata = 32'd0;
      endcase
   end

   assign cfg.mode    = mode_ff;
   assign cfg.swap    = swap_ff;
   assign cfg.dit_len = dit_ff;
   assign cfg.dah_len = dah_ff;

endmodule

>>> rtl/imk_core.sv
// imk_core: keyer state machine, stuck key check, ms timer and result skid buffer
// depends on imk_pkg; configuration arrives from imk_csr as a struct
`timescale 1ns / 1ps

module imk_core (
   input  logic                 clock,
   input  logic                 reset,
   input  imk_pkg::imk_cfg_type cfg,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic                 req_tip_pressed,
   input  logic                 req_ring_pressed,
   input  logic                 req_ms_elapsed,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic [1:0]           rsp_key_event,
   output logic [1:0]           rsp_error_event,
   output logic                 rsp_key_down
);
   import imk_pkg::*;

   typedef enum logic [2:0] {
      PH_IDLE    = 3'd0,
      PH_CHK_DIT = 3'd1,
      PH_CHK_DAH = 3'd2,
      PH_PREP    = 3'd3,
      PH_KEYED   = 3'd4,
      PH_GAP     = 3'd5
   } phase_type;

   phase_type             phase_ff, phase_in;
   logic                  dit_lat_ff, dit_lat_in;
   logic                  dah_lat_ff, dah_lat_in;
   logic                  dit_prog_ff, dit_prog_in;
   logic                  passed_ff, passed_in;
   logic                  err_ff, err_in;
   logic                  line_ff, line_in;
   logic [TIMER_BITS-1:0] elapsed_ff, elapsed_in;
   logic [TIMER_BITS-1:0] interval_ff, interval_in;
   logic [1:0]            kev, eev;
   logic                  dit_set, dah_set;

   logic                  out_v_ff;
   logic [1:0]            out_kev_ff, out_eev_ff;
   logic                  out_down_ff;
   logic                  skid_v_ff;
   logic [1:0]            skid_kev_ff, skid_eev_ff;
   logic                  skid_down_ff;
   logic                  accept, out_free;

   assign req_stall = skid_v_ff;
   assign accept    = req_valid & ~skid_v_ff;
   assign out_free  = ~out_v_ff | ~rsp_stall;

   always_comb begin
      phase_in    = phase_ff;
      dit_lat_in  = dit_lat_ff;
      dah_lat_in  = dah_lat_ff;
      dit_prog_in = dit_prog_ff;
      passed_in   = passed_ff;
      err_in      = err_ff;
      line_in     = line_ff;
      interval_in = interval_ff;
      kev         = KEY_NONE;
      eev         = ERR_NONE;
      elapsed_in  = (req_ms_elapsed && elapsed_ff != TIMER_MAX) ? elapsed_ff + 1'b1
                                                              : elapsed_ff;
      // paddle mapping after optional swap
      dit_set = cfg.swap ? req_ring_pressed : req_tip_pressed;
      dah_set = cfg.swap ? req_tip_pressed : req_ring_pressed;

      if (cfg.mode == MODE_STRAIGHT) begin
         if (req_tip_pressed) begin
            if (!passed_ff) begin
               if (!err_ff) begin
                  err_in = 1'b1;
                  eev    = ERR_STUCK;
               end
            end else if (!line_ff) begin
               line_in = 1'b1;
               kev     = KEY_PRESS;
            end
         end else begin
            passed_in = 1'b1;
            if (err_ff) begin
               err_in = 1'b0;
               eev    = ERR_CLEAR;
            end
            if (line_ff) begin
               line_in = 1'b0;
               kev     = KEY_RELEASE;
            end
         end
      end else begin
         unique case (phase_ff)
            PH_CHK_DIT: begin
               if (dit_lat_ff) begin
                  dit_prog_in = 1'b1;
                  interval_in = cfg.dit_len;
                  phase_in    = PH_PREP;
               end else begin
                  phase_in = PH_CHK_DAH;
               end
            end
            PH_CHK_DAH: begin
               if (dah_lat_ff) begin
                  interval_in = cfg.dah_len;
                  phase_in    = PH_PREP;
               end else begin
                  phase_in = PH_IDLE;
               end
            end
            PH_PREP: begin
               if (!line_ff) begin
                  kev = KEY_PRESS;
               end
               line_in    = 1'b1;
               elapsed_in = '0;
               dit_lat_in = 1'b0;
               dah_lat_in = 1'b0;
               phase_in   = PH_KEYED;
            end
            PH_KEYED: begin
               if (elapsed_in > interval_ff) begin
                  if (line_ff) begin
                     kev = KEY_RELEASE;
                  end
                  line_in     = 1'b0;
                  elapsed_in  = '0;
                  interval_in = cfg.dit_len;
                  phase_in    = PH_GAP;
               end else if (cfg.mode == MODE_IAMBIC_B) begin
                  dit_lat_in = dit_lat_ff | dit_set;
                  dah_lat_in = dah_lat_ff | dah_set;
               end
            end
            PH_GAP: begin
               dit_lat_in = dit_lat_ff | dit_set;
               dah_lat_in = dah_lat_ff | dah_set;
               if (elapsed_in > interval_ff) begin
                  if (dit_prog_ff) begin
                     dit_lat_in  = 1'b0;
                     dit_prog_in = 1'b0;
                     phase_in    = PH_CHK_DAH;
                  end else begin
                     dah_lat_in = 1'b0;
                     phase_in   = PH_IDLE;
                  end
               end
            end
            default: begin
               // idle, and the unused phase codes
               if (req_tip_pressed || req_ring_pressed || dit_lat_ff || dah_lat_ff) begin
                  if (!passed_ff) begin
                     if (!err_ff) begin
                        err_in = 1'b1;
                        eev    = ERR_STUCK;
                     end
                  end else begin
                     dit_lat_in = dit_lat_ff | dit_set;
                     dah_lat_in = dah_lat_ff | dah_set;
                     phase_in   = PH_CHK_DIT;
                  end
               end else begin
                  passed_in = 1'b1;
                  if (err_ff) begin
                     err_in = 1'b0;
                     eev    = ERR_CLEAR;
                  end
                  phase_in = PH_IDLE;
               end
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= PH_IDLE;
         dit_lat_ff  <= 1'b0;
         dah_lat_ff  <= 1'b0;
         dit_prog_ff <= 1'b0;
         passed_ff   <= 1'b0;
         err_ff      <= 1'b0;
         line_ff     <= 1'b0;
         elapsed_ff  <= '0;
         interval_ff <= '0;
         out_v_ff    <= 1'b0;
         skid_v_ff   <= 1'b0;
      end else begin
         if (accept) begin
            phase_ff    <= phase_in;
            dit_lat_ff  <= dit_lat_in;
            dah_lat_ff  <= dah_lat_in;
            dit_prog_ff <= dit_prog_in;
            passed_ff   <= passed_in;
            err_ff      <= err_in;
            line_ff     <= line_in;
            elapsed_ff  <= elapsed_in;
            interval_ff <= interval_in;
         end
         if (out_free) begin
            if (skid_v_ff) begin
               out_v_ff  <= 1'b1;
               skid_v_ff <= 1'b0;
            end else begin
               out_v_ff <= accept;
            end
         end else if (accept) begin
            skid_v_ff <= 1'b1;
         end
      end
   end

   // result payload, no reset needed
   always_ff @(posedge clock) begin
      if (out_free) begin
         if (skid_v_ff) begin
            out_kev_ff  <= skid_kev_ff;
            out_eev_ff  <= skid_eev_ff;
            out_down_ff <= skid_down_ff;
         end else if (accept) begin
            out_kev_ff  <= kev;
            out_eev_ff  <= eev;
            out_down_ff <= line_in;
         end
      end else if (accept) begin
         skid_kev_ff  <= kev;
         skid_eev_ff  <= eev;
         skid_down_ff <= line_in;
      end
   end

   assign rsp_valid       = out_v_ff;
   assign rsp_key_event   = out_kev_ff;
   assign rsp_error_event = out_eev_ff;
   assign rsp_key_down    = out_down_ff;

endmodule

>>> rtl/imk_checker.sv
// imk_checker: port-level assertions for the keyer, bound to the top level
// depends on imk_pkg for the event codes
`timescale 1ns / 1ps

module imk_checker (
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_stall,
   input logic [1:0] rsp_key_event,
   input logic [1:0] rsp_error_event,
   input logic       rsp_key_down
);
   import imk_pkg::*;

   // a stalled item holds its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_key_event)
         && $stable(rsp_error_event) && $stable(rsp_key_down))
      else $error("rsp item changed while stalled");

   a_press_level: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_key_event == KEY_PRESS |-> rsp_key_down)
      else $error("press event with key line up");

   a_release_level: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_key_event == KEY_RELEASE |-> !rsp_key_down)
      else $error("release event with key line down");

   // a stuck key event never comes with a key event or with the line keyed
   a_err_no_key: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_error_event != ERR_NONE |-> rsp_key_event == KEY_NONE && !rsp_key_down)
      else $error("key activity together with a stuck key event");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result pending after reset");

endmodule

bind iambic_morse_keyer imk_checker u_imk_checker (.*);

>>> tb/tb.sv
// tb: self-checking bench for iambic_morse_keyer, with an item-level keyer predictor
// depends on imk_pkg and rtl/iambic_morse_keyer.sv; drives req/csr, checks rsp and csr readback
`timescale 1ns / 1ps

module tb;
   import imk_pkg::*;

   localparam int DIT_BASE_MS = 1200;

   localparam logic [3:0] ADDR_MODE = 4'h0;
   localparam logic [3:0] ADDR_WPM  = 4'h4;
   localparam logic [3:0] ADDR_SWAP = 4'h8;

   localparam logic [1:0] MODE_SPARE = 2'd3;

   typedef enum logic [2:0] {
      KP_IDLE, KP_CHK_DIT, KP_CHK_DAH, KP_PREP, KP_KEYED, KP_GAP
   } keyer_phase_type;

   typedef struct packed {
      logic tip;
      logic ring;
      logic tick;
   } paddle_sample_type;

   typedef struct packed {
      logic [1:0] key_ev;
      logic [1:0] err_ev;
      logic       key_dn;
   } keyer_result_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic        req_tip_pressed = 1'b0;
   logic        req_ring_pressed = 1'b0;
   logic        req_ms_elapsed = 1'b0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [1:0]  rsp_key_event;
   logic [1:0]  rsp_error_event;
   logic        rsp_key_down;
   logic        csr_psel = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite = 1'b0;
   logic [3:0]  csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   iambic_morse_keyer u_dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_tip_pressed (req_tip_pressed),
      .req_ring_pressed(req_ring_pressed),
      .req_ms_elapsed  (req_ms_elapsed),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_key_event   (rsp_key_event),
      .rsp_error_event (rsp_error_event),
      .rsp_key_down    (rsp_key_down),
      .csr_psel        (csr_psel),
      .csr_penable     (csr_penable),
      .csr_pwrite      (csr_pwrite),
      .csr_paddr       (csr_paddr),
      .csr_pwdata      (csr_pwdata),
      .csr_prdata      (csr_prdata),
      .csr_pready      (csr_pready)
   );

   always #6 clock = ~clock;

   // predictor copy of the keyer registers and state
   logic [1:0]            cfg_mode = MODE_STRAIGHT;
   logic [6:0]            cfg_wpm = 7'd12;
   logic                  cfg_swap = 1'b0;
   keyer_phase_type       kp_phase = KP_IDLE;
   logic                  kp_dit_latch = 1'b0;
   logic                  kp_dah_latch = 1'b0;
   logic                  kp_dit_busy = 1'b0;
   logic                  kp_check_ok = 1'b0;
   logic                  kp_stuck = 1'b0;
   logic [TIMER_BITS-1:0] kp_elapsed = '0;
   logic [TIMER_BITS-1:0] kp_interval = '0;
   logic                  kp_line = 1'b0;

   paddle_sample_type paddle_samples[$];
   keyer_result_type  expected_events[$];

   int   fail_count = 0;
   int   items_taken = 0;
   int   presses_seen = 0;
   int   stuck_seen = 0;
   int   settings_used = 0;
   logic steady = 1'b0;
   int   hold_asked = 0;
   int   hold_served = 0;
   int   hold_left = 0;

   paddle_sample_type drv_sample;
   keyer_result_type  drv_result;
   keyer_result_type  mon_expect;

   function automatic logic [TIMER_BITS-1:0] element_len(input logic [6:0] wpm,
                                                          input int dits);
      int w;
      int len;
      w = (wpm == 7'd0) ? 1 : int'(wpm);
      len = (DIT_BASE_MS / w) * dits;
      if (len > int'(INTERVAL_CAP)) len = int'(INTERVAL_CAP);
      return len[TIMER_BITS-1:0];
   endfunction

   function automatic logic [1:0] set_line(input logic level);
      if (kp_line == level) return KEY_NONE;
      kp_line = level;
      return level ? KEY_PRESS : KEY_RELEASE;
   endfunction

   function automatic logic [1:0] raise_stuck();
      if (kp_stuck) return ERR_NONE;
      kp_stuck = 1'b1;
      return ERR_STUCK;
   endfunction

   function automatic logic [1:0] clear_stuck();
      kp_check_ok = 1'b1;
      if (!kp_stuck) return ERR_NONE;
      kp_stuck = 1'b0;
      return ERR_CLEAR;
   endfunction

   function automatic void latch_contacts(input logic tip, input logic ring);
      if (ring) begin
         if (cfg_swap) kp_dit_latch = 1'b1;
         else kp_dah_latch = 1'b1;
      end
      if (tip) begin
         if (cfg_swap) kp_dah_latch = 1'b1;
         else kp_dit_latch = 1'b1;
      end
   endfunction

   function automatic keyer_result_type step_keyer(input logic tip, input logic ring,
                                                   input logic tick);
      keyer_result_type r;
      r.key_ev = KEY_NONE;
      r.err_ev = ERR_NONE;
      if (tick && kp_elapsed != TIMER_MAX) kp_elapsed = kp_elapsed + 1'b1;
      if (cfg_mode == MODE_STRAIGHT) begin
         if (tip) begin
            if (!kp_check_ok) r.err_ev = raise_stuck();
            else r.key_ev = set_line(1'b1);
         end else begin
            r.err_ev = clear_stuck();
            r.key_ev = set_line(1'b0);
         end
      end else begin
         case (kp_phase)
            KP_CHK_DIT: begin
               if (kp_dit_latch) begin
                  kp_dit_busy = 1'b1;
                  kp_interval = element_len(cfg_wpm, 1);
                  kp_phase = KP_PREP;
               end else begin
                  kp_phase = KP_CHK_DAH;
               end
            end
            KP_CHK_DAH: begin
               if (kp_dah_latch) begin
                  kp_interval = element_len(cfg_wpm, DAH_DITS);
                  kp_phase = KP_PREP;
               end else begin
                  kp_phase = KP_IDLE;
               end
            end
            KP_PREP: begin
               r.key_ev = set_line(1'b1);
               kp_elapsed = '0;
               kp_dit_latch = 1'b0;
               kp_dah_latch = 1'b0;
               kp_phase = KP_KEYED;
            end
            KP_KEYED: begin
               if (kp_elapsed > kp_interval) begin
                  r.key_ev = set_line(1'b0);
                  kp_elapsed = '0;
                  kp_interval = element_len(cfg_wpm, 1);
                  kp_phase = KP_GAP;
               end else if (cfg_mode == MODE_IAMBIC_B) begin
                  latch_contacts(tip, ring);
               end
            end
            KP_GAP: begin
               latch_contacts(tip, ring);
               if (kp_elapsed > kp_interval) begin
                  if (kp_dit_busy) begin
                     kp_dit_latch = 1'b0;
                     kp_dit_busy = 1'b0;
                     kp_phase = KP_CHK_DAH;
                  end else begin
                     kp_dah_latch = 1'b0;
                     kp_phase = KP_IDLE;
                  end
               end
            end
            default: begin
               if (tip || ring || kp_dit_latch || kp_dah_latch) begin
                  if (!kp_check_ok) begin
                     r.err_ev = raise_stuck();
                  end else begin
                     latch_contacts(tip, ring);
                     kp_phase = KP_CHK_DIT;
                  end
               end else begin
                  r.err_ev = clear_stuck();
                  kp_phase = KP_IDLE;
               end
            end
         endcase
      end
      r.key_dn = kp_line;
      return r;
   endfunction

   // sender: offers queued samples, holds the payload while stalled
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            drv_result = step_keyer(req_tip_pressed, req_ring_pressed, req_ms_elapsed);
            expected_events.push_back(drv_result);
            items_taken++;
            if (drv_result.key_ev == KEY_PRESS) presses_seen++;
            if (drv_result.err_ev != ERR_NONE) stuck_seen++;
         end
         if (!req_valid || !req_stall) begin
            if (paddle_samples.size() != 0 && (steady || $urandom_range(99) >= 6)) begin
               drv_sample = paddle_samples.pop_front();
               req_valid <= 1'b1;
               req_tip_pressed <= drv_sample.tip;
               req_ring_pressed <= drv_sample.ring;
               req_ms_elapsed <= drv_sample.tick;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // receiver: checks each result against the oldest prediction
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         hold_left <= 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_events.size() == 0) begin
               fail_count++;
               $display("%0t unexpected result: expected none, actual key %0d err %0d down %0d",
                        $time, rsp_key_event, rsp_error_event, rsp_key_down);
            end else begin
               mon_expect = expected_events.pop_front();
               if (rsp_key_event !== mon_expect.key_ev) begin
                  fail_count++;
                  $display("%0t key_event expected %0d actual %0d",
                           $time, mon_expect.key_ev, rsp_key_event);
               end
               if (rsp_error_event !== mon_expect.err_ev) begin
                  fail_count++;
                  $display("%0t error_event expected %0d actual %0d",
                           $time, mon_expect.err_ev, rsp_error_event);
               end
               if (rsp_key_down !== mon_expect.key_dn) begin
                  fail_count++;
                  $display("%0t key_down expected %0d actual %0d",
                           $time, mon_expect.key_dn, rsp_key_down);
               end
            end
         end
         if (hold_served != hold_asked) begin
            hold_served <= hold_asked;
            hold_left <= 80;
            rsp_stall <= 1'b1;
         end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= !steady && ($urandom_range(99) < 6);
         end
      end
   end

   task automatic push_sample(input logic tip, input logic ring, input logic tick);
      paddle_sample_type s;
      s.tip = tip;
      s.ring = ring;
      s.tick = tick;
      paddle_samples.push_back(s);
   endtask

   task automatic push_idle_ticks(input int count);
      repeat (count) push_sample(1'b0, 1'b0, 1'b1);
   endtask

   // held paddle patterns with random tick spacing, plus some pure noise
   task automatic push_random_bursts(input int count);
      int pushed;
      int len;
      int kind;
      logic tip;
      logic ring;
      pushed = 0;
      while (pushed < count) begin
         kind = $urandom_range(99);
         if (kind < 10) begin
            push_sample(1'($urandom_range(1)), 1'($urandom_range(1)),
                        1'($urandom_range(1)));
            pushed++;
         end else begin
            kind = $urandom_range(99);
            tip = (kind >= 30 && kind < 55) || kind >= 80;
            ring = (kind >= 55);
            len = $urandom_range(1, 30);
            repeat (len) push_sample(tip, ring, $urandom_range(99) < 80);
            pushed += len;
         end
      end
   endtask

   task automatic csr_write(input logic [3:0] addr, input logic [31:0] value);
      logic [31:0] stored;
      @(posedge clock);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= addr;
      csr_pwdata <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      case (addr)
         ADDR_MODE: begin
            cfg_mode = value[1:0];
            stored = {30'd0, value[1:0]};
         end
         ADDR_WPM: begin
            cfg_wpm = value[6:0];
            stored = {25'd0, value[6:0]};
         end
         default: begin
            cfg_swap = value[0];
            stored = {31'd0, value[0]};
         end
      endcase
      // read back through the same port
      @(posedge clock);
      csr_psel <= 1'b1;
      csr_pwrite <= 1'b0;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(negedge clock);
      if (csr_prdata !== stored) begin
         fail_count++;
         $display("%0t csr readback at %0h expected %0h actual %0h",
                  $time, addr, stored, csr_prdata);
      end
      @(posedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   task automatic configure(input logic [1:0] mode, input logic [6:0] wpm,
                            input logic swap);
      csr_write(ADDR_MODE, {30'd0, mode});
      csr_write(ADDR_WPM, {25'd0, wpm});
      csr_write(ADDR_SWAP, {31'd0, swap});
      settings_used++;
   endtask

   // wait for every queued item to come back, then a little latency slack
   task automatic drain();
      int n;
      n = 0;
      while ((paddle_samples.size() != 0 || req_valid || expected_events.size() != 0)
             && n < 100000) begin
         @(posedge clock);
         n++;
      end
      repeat (6) @(posedge clock);
   endtask

   initial begin
      int r;
      logic [1:0] mode;
      logic [6:0] wpm;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // straight key after reset: stuck tip, release clears it, then normal keying
      push_sample(1'b1, 1'b0, 1'b1);
      push_sample(1'b1, 1'b1, 1'b0);
      push_sample(1'b0, 1'b1, 1'b1);
      push_sample(1'b1, 1'b0, 1'b0);
      push_sample(1'b1, 1'b1, 1'b1);
      push_sample(1'b0, 1'b0, 1'b0);
      drain();

      // mode b at top speed, swapped, both paddles squeezed
      configure(MODE_IAMBIC_B, 7'd127, 1'b1);
      repeat (16) push_sample(1'b1, 1'b1, 1'b1);
      push_sample(1'b0, 1'b0, 1'b1);
      push_sample(1'b0, 1'b0, 1'b0);
      drain();

      for (int p = 0; p < 12; p++) begin
         r = $urandom_range(99);
         mode = (r < 15) ? MODE_STRAIGHT : (r < 50) ? MODE_IAMBIC_A :
                (r < 90) ? MODE_IAMBIC_B : MODE_SPARE;
         if (p == 0) mode = MODE_IAMBIC_A;
         if (p == 1) mode = MODE_SPARE;
         if (p == 2) mode = MODE_STRAIGHT;
         r = $urandom_range(99);
         wpm = (r < 15) ? 7'd127 : (r < 25) ? 7'($urandom_range(1, 127)) :
               7'($urandom_range(80, 127));
         configure(mode, wpm, 1'($urandom_range(1)));
         steady = (p == 5);
         push_random_bursts(110);
         if (p == 7) hold_asked++;
         drain();
         steady = 1'b0;
      end

      // settle to idle, then a zero-speed dah
      configure(MODE_IAMBIC_A, 7'd127, 1'b0);
      push_idle_ticks(200);
      drain();
      configure(MODE_IAMBIC_B, 7'd0, 1'b0);
      repeat (3) push_sample(1'b0, 1'b1, 1'b1);
      push_idle_ticks(60);
      drain();

      // straight keying while the iambic element stays parked
      configure(MODE_STRAIGHT, 7'd0, 1'b0);
      push_random_bursts(100);
      drain();

      if (expected_events.size() != 0) begin
         fail_count++;
         $display("%0t %0d results never arrived", $time, expected_events.size());
      end
      $display("covered %0d paddle samples across %0d register settings", items_taken,
               settings_used);
      $display("predicted %0d key presses and %0d stuck-key events", presses_seen,
               stuck_seen);
      if (fail_count == 0) begin
         $display("tb OK");
      end else begin
         $display("tb NOT OK");
      end
      $finish;
   end

   initial begin
      #4000000;
      $display("tb NOT OK");
      $finish;
   end

endmodule

>>> sim.f
rtl/imk_pkg.sv
rtl/imk_csr.sv
rtl/imk_core.sv
rtl/iambic_morse_keyer.sv
rtl/imk_checker.sv
tb/tb.sv
